@@ rtl/kesp_pkg.sv @@
`timescale 1ns / 1ps

package kesp_pkg;

    localparam int KEYS   = 6;
    localparam int KEY_W  = $clog2(KEYS);
    localparam int CNT_W  = $clog2(KEYS + 1);
    localparam int SLOT_W = 3;
    localparam int TIME_W = 32;

    // key phase codes
    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_RISE = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_FALL = 2'd3;

    localparam logic [SLOT_W-1:0] SLOT_EMPTY = 3'd7;

    typedef struct packed {
        logic [KEYS-1:0]   key_levels;
        logic [TIME_W-1:0] now_ms;
        logic [2:0]        query_key;
    } in_item_t;

    typedef struct packed {
        logic [11:0]       key_phases;
        logic [17:0]       order_list;
        logic [2:0]        pressed_count;
        logic [1:0]        query_phase;
        logic [2:0]        query_order;
        logic [TIME_W-1:0] query_stamp;
    } out_item_t;

    typedef struct packed {
        logic             load_in;
        logic             step;
        logic             load_out;
        logic [KEY_W-1:0] key_idx;
    } kesp_cmd_t;

endpackage

@@ rtl/kesp_ctrl.sv @@
`timescale 1ns / 1ps

module kesp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output kesp_pkg::kesp_cmd_t cmd
);
    import kesp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [KEY_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.key_idx    = cnt_reg;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == KEY_W'(KEYS - 1))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                // result register free or emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/kesp_datapath.sv @@
`timescale 1ns / 1ps

module kesp_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kesp_pkg::kesp_cmd_t  cmd,
    input  kesp_pkg::in_item_t   in_data,
    output kesp_pkg::out_item_t  out_data
);
    import kesp_pkg::*;

    logic [1:0]        phase_reg [KEYS];
    logic [1:0]        phase_next;
    logic [TIME_W-1:0] stamp_reg [KEYS];
    logic              stamp_en;
    logic [SLOT_W-1:0] order_reg [KEYS];
    logic [SLOT_W-1:0] order_next [KEYS];
    logic [CNT_W-1:0]  total_reg, total_next;

    in_item_t          frame_reg;
    out_item_t         out_reg, out_next;

    logic [1:0]        ph;
    logic              was_down, is_down;
    logic [SLOT_W-1:0] key_code;
    logic              found;
    logic [KEY_W-1:0]  pos;
    logic [SLOT_W-1:0] removed [KEYS];
    logic [CNT_W-1:0]  removed_total;

    logic              q_found;
    logic [KEY_W-1:0]  q_pos;

    // one key per step: phase update and list edit
    always_comb
    begin
        ph       = phase_reg[cmd.key_idx];
        was_down = (ph == PH_RISE) || (ph == PH_HIGH);
        is_down  = frame_reg.key_levels[cmd.key_idx];
        key_code = SLOT_W'(cmd.key_idx);

        phase_next = ph;
        stamp_en   = 1'b0;
        if (was_down != is_down)
        begin
            phase_next = is_down ? PH_RISE : PH_FALL;
            stamp_en   = 1'b1;
        end
        else if (ph == PH_RISE)
        begin
            phase_next = PH_HIGH;
            stamp_en   = 1'b1;
        end
        else if (ph == PH_FALL)
        begin
            phase_next = PH_LOW;
            stamp_en   = 1'b1;
        end

        // locate the key among the listed slots
        found = 1'b0;
        pos   = '0;
        for (int s = KEYS - 1; s >= 0; s--)
        begin
            if ((CNT_W'(s) < total_reg) && (order_reg[s] == key_code))
            begin
                found = 1'b1;
                pos   = KEY_W'(s);
            end
        end

        // compact over the removed slot
        removed_total = total_reg;
        for (int s = 0; s < KEYS; s++)
        begin
            removed[s] = order_reg[s];
        end
        if (found)
        begin
            removed_total = total_reg - 1'b1;
            for (int s = 0; s < KEYS; s++)
            begin
                if (KEY_W'(s) >= pos && CNT_W'(s) < total_reg)
                begin
                    if (CNT_W'(s + 1) < total_reg)
                    begin
                        removed[s] = order_reg[(s + 1) % KEYS];
                    end
                    else
                    begin
                        removed[s] = SLOT_EMPTY;
                    end
                end
            end
        end

        for (int s = 0; s < KEYS; s++)
        begin
            order_next[s] = order_reg[s];
        end
        total_next = total_reg;
        if (was_down != is_down)
        begin
            if (is_down)
            begin
                // append unless full
                if (total_reg < CNT_W'(KEYS))
                begin
                    for (int s = 0; s < KEYS; s++)
                    begin
                        order_next[s] = (CNT_W'(s) == removed_total) ? key_code
                                                                     : removed[s];
                    end
                    total_next = removed_total + 1'b1;
                end
            end
            else
            begin
                for (int s = 0; s < KEYS; s++)
                begin
                    order_next[s] = removed[s];
                end
                total_next = removed_total;
            end
        end
    end

    // result assembly from the settled state
    always_comb
    begin
        q_found = 1'b0;
        q_pos   = '0;
        for (int s = KEYS - 1; s >= 0; s--)
        begin
            if ((CNT_W'(s) < total_reg) && (order_reg[s] == SLOT_W'(frame_reg.query_key)))
            begin
                q_found = 1'b1;
                q_pos   = KEY_W'(s);
            end
        end

        out_next = '0;
        for (int i = 0; i < KEYS; i++)
        begin
            out_next.key_phases[2*i +: 2] = phase_reg[i];
            out_next.order_list[3*i +: 3] = order_reg[i];
        end
        out_next.pressed_count = 3'(total_reg);
        out_next.query_phase   = PH_LOW;
        out_next.query_order   = SLOT_EMPTY;
        out_next.query_stamp   = '0;
        if (frame_reg.query_key < 3'(KEYS))
        begin
            out_next.query_phase = phase_reg[KEY_W'(frame_reg.query_key)];
            out_next.query_stamp = stamp_reg[KEY_W'(frame_reg.query_key)];
            if (q_found)
            begin
                out_next.query_order = 3'(q_pos);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEYS; i++)
            begin
                phase_reg[i] <= PH_LOW;
                stamp_reg[i] <= '0;
                order_reg[i] <= SLOT_EMPTY;
            end
            total_reg <= '0;
        end
        else if (cmd.step)
        begin
            phase_reg[cmd.key_idx] <= phase_next;
            if (stamp_en)
            begin
                stamp_reg[cmd.key_idx] <= frame_reg.now_ms;
            end
            for (int s = 0; s < KEYS; s++)
            begin
                order_reg[s] <= order_next[s];
            end
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            frame_reg <= in_data;
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

@@ rtl/key_edge_state_and_press_order_top.sv @@
// sequence per item: accept, 6 key steps at one key per cycle, then the result load
// the sequencer takes no new item until its result is loaded; the load waits while the
// result register still holds an unread result
// the result register lets the next item be taken while a result waits to be read
// reset: asynchronous active low; all keys low, stamps zero, press list empty, no result held
`timescale 1ns / 1ps

module key_edge_state_and_press_order_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kesp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kesp_pkg::out_item_t out_data
);
    import kesp_pkg::*;

    // command bundle from sequencer to datapath
    kesp_cmd_t cmd;

    // sequencer: capture, walk keys in index order, then load the result
    kesp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath: key phases, stamps, press-order list and result register
    kesp_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

@@ sim/tb_key_edge_state_and_press_order_top.sv @@
`timescale 1ns / 1ps

module tb_key_edge_state_and_press_order_top;

    import kesp_pkg::*;

    // clock, reset and the two channels
    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    key_edge_state_and_press_order_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // 20 ns period
    always #10 clk = ~clk;

    // tracker copy of the key state, advanced once per accepted frame
    logic [1:0]  trk_phase [KEYS];
    logic [31:0] trk_stamp [KEYS];
    logic [2:0]  trk_order [KEYS];
    int          trk_count;

    // reports owed by the block, oldest first
    out_item_t expected_reports[$];
    int        errors;

    // idling controls, in percent per cycle
    int send_idle_pct;
    int recv_stall_pct;
    // long receiver hold-off, counted down by the receiver process
    int hold_left;

    // random frame source: held levels plus a running millisecond clock
    logic [KEYS-1:0] rand_levels;
    logic [31:0]     rand_clock_ms;

    // slot of a key in the press list, -1 if not listed
    function automatic int order_pos(logic [2:0] key);
        for (int s = 0; s < trk_count; s++)
        begin
            if (trk_order[s] == key)
                return s;
        end
        return -1;
    endfunction

    // take a key out of the press list and close the gap
    function automatic void drop_from_order(logic [2:0] key);
        int pos;
        pos = order_pos(key);
        if (pos < 0)
            return;
        for (int s = pos; s + 1 < trk_count; s++)
            trk_order[s] = trk_order[s + 1];
        trk_order[trk_count - 1] = SLOT_EMPTY;
        trk_count--;
    endfunction

    // newest press goes to the tail; a key is never listed twice
    function automatic void push_to_order(logic [2:0] key);
        if (trk_count >= KEYS)
            return;
        drop_from_order(key);
        trk_order[trk_count] = key;
        trk_count++;
    endfunction

    // advance the key tracker by one scanned frame and build the report it owes
    function automatic out_item_t track_frame(in_item_t frame);
        out_item_t  rep;
        logic [1:0] ph;
        logic       was_down;
        logic       is_down;
        int         pos;
        // keys in index order, so list appends follow the index
        for (int k = 0; k < KEYS; k++)
        begin
            ph       = trk_phase[k];
            was_down = (ph == PH_RISE) || (ph == PH_HIGH);
            is_down  = frame.key_levels[k];
            if (was_down != is_down)
            begin
                if (is_down)
                begin
                    trk_phase[k] = PH_RISE;
                    push_to_order(3'(k));
                end
                else
                begin
                    trk_phase[k] = PH_FALL;
                    drop_from_order(3'(k));
                end
                trk_stamp[k] = frame.now_ms;
            end
            else if (ph == PH_RISE)
            begin
                trk_phase[k] = PH_HIGH;
                trk_stamp[k] = frame.now_ms;
            end
            else if (ph == PH_FALL)
            begin
                trk_phase[k] = PH_LOW;
                trk_stamp[k] = frame.now_ms;
            end
        end
        rep = '0;
        for (int k = 0; k < KEYS; k++)
        begin
            rep.key_phases[2*k +: 2] = trk_phase[k];
            rep.order_list[3*k +: 3] = trk_order[k];
        end
        rep.pressed_count = 3'(trk_count);
        // a query past the last key reads as an idle, unlisted key
        rep.query_phase = PH_LOW;
        rep.query_order = SLOT_EMPTY;
        rep.query_stamp = '0;
        if (frame.query_key < KEYS)
        begin
            pos             = order_pos(frame.query_key);
            rep.query_phase = trk_phase[frame.query_key];
            rep.query_stamp = trk_stamp[frame.query_key];
            if (pos >= 0)
                rep.query_order = 3'(pos);
        end
        return rep;
    endfunction

    function automatic in_item_t make_frame(logic [KEYS-1:0] levels, logic [31:0] ms,
                                            logic [2:0] query);
        in_item_t f;
        f.key_levels = levels;
        f.now_ms     = ms;
        f.query_key  = query;
        return f;
    endfunction

    // mostly plausible scanning: a few keys change per frame, time creeps forward;
    // now and then a frame of pure noise or a jump in time
    function automatic in_item_t next_random_frame();
        if ($urandom_range(99) < 15)
            rand_levels = KEYS'($urandom_range(2**KEYS - 1));
        else
        begin
            for (int k = 0; k < KEYS; k++)
            begin
                if ($urandom_range(4) == 0)
                    rand_levels[k] = ~rand_levels[k];
            end
        end
        if ($urandom_range(9) == 0)
            rand_clock_ms = $urandom();
        else
            rand_clock_ms = rand_clock_ms + $urandom_range(1, 3);
        return make_frame(rand_levels, rand_clock_ms, 3'($urandom_range(7)));
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // offer one frame, with random idle cycles in front, and wait for the handshake
    task automatic send_frame(input in_item_t frame);
        if ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= frame;
        do
            @(posedge clk);
        while (!in_ready);
        expected_reports.push_back(track_frame(frame));
    endtask

    // stop offering and wait until every owed report has been taken
    task automatic wait_reports_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_burst(int count, int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
            send_frame(next_random_frame());
    endtask

    // hand-picked frames: settling, full press, compaction, direct toggles,
    // time extremes and queries past the last key
    task automatic test_directed_frames();
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        send_frame(make_frame(6'b000000, 32'd0, 3'd0));
        send_frame(make_frame(6'b000001, 32'd1, 3'd0));
        send_frame(make_frame(6'b000001, 32'd2, 3'd0));
        // every key down at once, listed in index order
        send_frame(make_frame(6'b111111, 32'd3, 3'd5));
        send_frame(make_frame(6'b111111, 32'd4, 3'd3));
        // release from the middle of the list, then the head
        send_frame(make_frame(6'b111101, 32'd5, 3'd2));
        send_frame(make_frame(6'b111100, 32'd6, 3'd0));
        send_frame(make_frame(6'b111100, 32'd7, 3'd6));
        // everything up at the top of the time range
        send_frame(make_frame(6'b000000, 32'hFFFF_FFFF, 3'd7));
        send_frame(make_frame(6'b000000, 32'hFFFF_FFFE, 3'd5));
        // later index pressed first, then release of the list head
        send_frame(make_frame(6'b100000, 32'd10, 3'd5));
        send_frame(make_frame(6'b100100, 32'd11, 3'd2));
        send_frame(make_frame(6'b000100, 32'd12, 3'd2));
        // rise straight to fall, and fall straight back to rise
        send_frame(make_frame(6'b010000, 32'd13, 3'd4));
        send_frame(make_frame(6'b000000, 32'd14, 3'd4));
        send_frame(make_frame(6'b010000, 32'd15, 3'd4));
        // opposite patterns: falls and rises in the same frame
        send_frame(make_frame(6'b101010, 32'd16, 3'd4));
        send_frame(make_frame(6'b010101, 32'd17, 3'd1));
        send_frame(make_frame(6'b010101, 32'h8000_0000, 3'd3));
        send_frame(make_frame(6'b000000, 32'h7FFF_FFFF, 3'd1));
        send_frame(make_frame(6'b000000, 32'h5555_AAAA, 3'd6));
        wait_reports_drained();
    endtask

    // random frames across the idling phases, including stretches with none
    task automatic test_random_frames();
        run_random_burst(250, 0, 0);
        run_random_burst(250, 83, 0);
        run_random_burst(250, 0, 83);
        run_random_burst(250, 27, 27);
    endtask

    // receiver holds off for a long stretch while frames keep coming,
    // so the block fills and stalls its input
    task automatic test_output_hold_off();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        repeat (12)
            send_frame(next_random_frame());
        wait_reports_drained();
    endtask

    // sender stops until every report is in, then carries on
    task automatic test_sender_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        repeat (20)
            send_frame(next_random_frame());
        wait_reports_drained();
        repeat (20)
            send_frame(next_random_frame());
        wait_reports_drained();
    endtask

    // receiver: random stalls, or a counted hold-off when one is asked for
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // report checker, compares each taken report with the oldest owed one
    always @(posedge clk)
    begin : report_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("report with none owed: %0h", out_data);
                errors++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("key_phases", 32'(want.key_phases), 32'(out_data.key_phases));
                check_field("order_list", 32'(want.order_list), 32'(out_data.order_list));
                check_field("pressed_count", 32'(want.pressed_count),
                            32'(out_data.pressed_count));
                check_field("query_phase", 32'(want.query_phase), 32'(out_data.query_phase));
                check_field("query_order", 32'(want.query_order), 32'(out_data.query_order));
                check_field("query_stamp", want.query_stamp, out_data.query_stamp);
            end
        end
    end

    // hard limit on the run
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        errors         = 0;
        hold_left      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rand_levels    = '0;
        rand_clock_ms  = 32'd100;
        for (int k = 0; k < KEYS; k++)
        begin
            trk_phase[k] = PH_LOW;
            trk_stamp[k] = '0;
            trk_order[k] = SLOT_EMPTY;
        end
        trk_count = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_random_frames();
        test_output_hold_off();
        test_sender_pause();

        // let anything still in flight surface before the verdict
        wait_reports_drained();
        repeat (16)
            @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
